/* hdl/lsmf_pkg.sv */
// Shared constants, types and the case-fold helper of the last-match finder.
package lsmf_pkg;

  // Pattern storage is fixed by the two 64-bit pattern registers
  localparam int PAT_BYTES       = 16;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_INDEX_W     = 2;
  localparam int LEN_W           = 5;
  localparam int POS_W           = 17;
  localparam int MAX_PATTERN_DEF = 16;
  localparam int MAX_TEXT_DEF    = 65536;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_FIRST_EIGHT = 2'd0,
    REG_PATTERN_LAST_EIGHT  = 2'd1,
    REG_PATTERN_LENGTH      = 2'd2,
    REG_IGNORE_CASE         = 2'd3
  } cfg_reg_t;

  // Configuration as seen by the window compare
  typedef struct packed {
    logic [PAT_BYTES-1:0][7:0] pattern;
    logic [LEN_W-1:0]          length;
    logic                      ignore_case;
  } lsmf_cfg_t;

  // Fold ASCII upper-case letters to lower case when asked
  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic fold_en);
    logic [7:0] r;
    r = c;
    if (fold_en && c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

/* hdl/lsmf_window_cmp.sv */
// Parallel compare of the newest window bytes against the configured pattern.
module lsmf_window_cmp
  import lsmf_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic [MAX_PATTERN-1:0][7:0] window,
  input  lsmf_cfg_t                   cfg,
  output logic                        match
);

  localparam int WIW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  // Pattern byte j lines up with window entry length-1-j (entry 0 is newest)
  always_comb begin
    logic       all_eq;
    logic [5:0] k;
    logic       en;
    logic [7:0] t;
    logic [7:0] p;
    all_eq = 1'b1;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      en = 6'(j) < {1'b0, cfg.length};
      k  = {1'b0, cfg.length} - 6'd1 - 6'(j);
      t  = fold_byte(window[k[WIW-1:0]], cfg.ignore_case);
      p  = fold_byte(cfg.pattern[j], cfg.ignore_case);
      if (en && (t != p)) begin
        all_eq = 1'b0;
      end
    end
    match = all_eq && (cfg.length != '0) &&
            ({1'b0, cfg.length} <= 6'(MAX_PATTERN));
  end

endmodule

/* hdl/last_substring_match_finder_unit.sv */
// Top level of the last-match finder: config registers, input stage, stream state, result.
//
// Text bytes arrive one item per cycle; each byte enters an input register, and from there
// it shifts into a window of the newest MAX_PATTERN bytes, which is compared in one pass
// against the pattern (exact or ASCII case folded). The item marked is_last passes from the
// input register into the result register and clears the stream state; items follow back to
// back at one per cycle, and the input stalls only when a last item meets a result still
// waiting to be taken. An empty pattern reports found at the number of bytes kept; bytes
// beyond MAX_TEXT are dropped and reported through text_overflow. Write configuration only
// while no text is in flight.
module last_substring_match_finder_unit
  import lsmf_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int MAX_TEXT    = MAX_TEXT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             text_byte,
  input  logic                   byte_present,
  input  logic                   is_last,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   found,
  output logic [POS_W-1:0]       match_position,
  output logic                   text_overflow
);

  localparam int CW = $clog2(MAX_TEXT + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  // Configuration registers
  logic [CFG_DATA_W-1:0] pattern_first_eight;
  logic [CFG_DATA_W-1:0] pattern_last_eight;
  logic [LEN_W-1:0]      pattern_length;
  logic                  ignore_case;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_first_eight <= '0;
      pattern_last_eight  <= '0;
      pattern_length      <= '0;
      ignore_case         <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_PATTERN_FIRST_EIGHT: pattern_first_eight <= cfg_data;
        REG_PATTERN_LAST_EIGHT:  pattern_last_eight  <= cfg_data;
        REG_PATTERN_LENGTH:      pattern_length      <= cfg_data[LEN_W-1:0];
        REG_IGNORE_CASE:         ignore_case         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  lsmf_cfg_t cfg;
  assign cfg.pattern     = {pattern_last_eight, pattern_first_eight};
  assign cfg.length      = pattern_length;
  assign cfg.ignore_case = ignore_case;

  // Input stage
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_present;
  logic       s1_last;
  logic       s1_go;
  logic       in_take;

  // A last item waits only while the result register is still held
  assign s1_go    = s1_valid && !(s1_last && out_valid && out_stall);
  assign in_stall = s1_valid && !s1_go;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte    <= text_byte;
      s1_present <= byte_present;
      s1_last    <= is_last;
    end
  end

  // Stream state
  logic [MAX_PATTERN-1:0][7:0] window;
  logic [MAX_PATTERN-1:0][7:0] window_next;
  logic [CW-1:0]               bytes_seen;
  logic [CW-1:0]               bytes_seen_next;
  logic                        match_seen;
  logic                        match_seen_next;
  logic [CW-1:0]               latest_start;
  logic [CW-1:0]               latest_start_next;
  logic                        overflowed;
  logic                        overflowed_next;
  logic                        keep_byte;
  logic                        window_match;

  assign keep_byte = s1_present && (bytes_seen < CW'(MAX_TEXT));

  // Shift the new byte in at entry 0
  always_comb begin
    window_next = window;
    if (keep_byte) begin
      window_next[0] = s1_byte;
      for (int i = 1; i < MAX_PATTERN; i++) begin
        window_next[i] = window[i-1];
      end
    end
  end

  lsmf_window_cmp #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_cmp (
    .window(window_next),
    .cfg   (cfg),
    .match (window_match)
  );

  // Advance count, overflow flag and latest match start
  always_comb begin
    bytes_seen_next   = bytes_seen;
    match_seen_next   = match_seen;
    latest_start_next = latest_start;
    overflowed_next   = overflowed || (s1_present && !keep_byte);
    if (keep_byte) begin
      bytes_seen_next = bytes_seen + CW'(1);
      if (window_match && (bytes_seen_next >= CW'(pattern_length))) begin
        match_seen_next   = 1'b1;
        latest_start_next = bytes_seen_next - CW'(pattern_length);
      end
    end
  end

  // Window holds payload only; a match over entries past the byte count is never taken
  always_ff @(posedge clk) begin
    if (s1_go) begin
      window <= window_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen   <= '0;
      match_seen   <= 1'b0;
      latest_start <= '0;
      overflowed   <= 1'b0;
    end else if (s1_go) begin
      if (s1_last) begin
        bytes_seen   <= '0;
        match_seen   <= 1'b0;
        latest_start <= '0;
        overflowed   <= 1'b0;
      end else begin
        bytes_seen   <= bytes_seen_next;
        match_seen   <= match_seen_next;
        latest_start <= latest_start_next;
        overflowed   <= overflowed_next;
      end
    end
  end

  // Result register
  logic          res_found;
  logic [XW-1:0] res_pos;

  always_comb begin
    if (pattern_length == '0) begin
      res_found = 1'b1;
      res_pos   = XW'(bytes_seen_next);
    end else if (match_seen_next) begin
      res_found = 1'b1;
      res_pos   = XW'(latest_start_next);
    end else begin
      res_found = 1'b0;
      res_pos   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last) begin
      found          <= res_found;
      match_position <= res_pos[POS_W-1:0];
      text_overflow  <= overflowed_next;
    end
  end

  // Checks
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && s1_last && out_valid))
    else $error("input stalled without a blocked last item");

  assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_last) |=> (bytes_seen == '0 && !match_seen && !overflowed && out_valid))
    else $error("stream state not cleared after last item");

  assert property (@(posedge clk) disable iff (rst)
    bytes_seen <= CW'(MAX_TEXT))
    else $error("byte count beyond text limit");

  assert property (@(posedge clk) disable iff (rst)
    latest_start <= bytes_seen)
    else $error("match start beyond bytes seen");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (match_position == '0))
    else $error("position nonzero on not-found result");

endmodule
